FILE: rtl/csm_pkg.sv
// shared types, constants and helpers for the case-insensitive substring matcher
package csm_pkg;

    localparam int NEEDLE_MAX = 16;
    localparam int NEEDLE_W   = 8 * NEEDLE_MAX;
    localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);
    localparam int IDX_W      = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int POS_W      = 16;
    localparam int START_W    = 16;
    localparam int CNT_W      = 16;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LOW  = 2'd0,
        CFG_NEEDLE_HIGH = 2'd1,
        CFG_NEEDLE_LEN  = 2'd2
    } t_cfg_index;

    typedef enum logic {
        KIND_MATCH   = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [START_W-1:0] start;
        logic [CNT_W-1:0]   total;
        logic               any;
        logic               last;
    } t_result;

    // up to two results leave the matcher for one text byte
    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

    // fold ascii lower case letters to upper case
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h61:8'h7A]}) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: rtl/csm_matcher.sv
// text window, parallel needle compare and match bookkeeping
module csm_matcher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [7:0]                     i_byte,
    input  logic                           i_last,
    input  logic [csm_pkg::NEEDLE_W-1:0]   i_needle,
    input  logic [csm_pkg::LEN_W-1:0]      i_len,
    output csm_pkg::t_push                 o_push
);

    logic [7:0]                  r_win [csm_pkg::NEEDLE_MAX];
    logic [7:0]                  n_win [csm_pkg::NEEDLE_MAX];
    logic [csm_pkg::LEN_W-1:0]   r_filled, n_filled;
    logic [csm_pkg::IDX_W-1:0]   r_blocked, n_blocked;
    logic [csm_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [csm_pkg::CNT_W-1:0]   r_total, n_total;

    logic                        cmp_ok;
    logic                        hit;
    logic [csm_pkg::LEN_W-1:0]   len_m1;
    logic [csm_pkg::LEN_W-1:0]   idx_full;
    logic [csm_pkg::POS_W-1:0]   start;
    csm_pkg::t_result            match_res;
    csm_pkg::t_result            sum_res;

    always_comb begin
        n_win[0] = csm_pkg::fold_byte(i_byte);
        for (int k = 1; k < csm_pkg::NEEDLE_MAX; k++) begin
            n_win[k] = r_win[k-1];
        end

        n_filled = (r_filled < csm_pkg::LEN_W'(csm_pkg::NEEDLE_MAX)) ?
                   r_filled + 1'b1 : r_filled;

        // needle byte k lines up with window entry len-1-k
        cmp_ok   = 1'b1;
        idx_full = '0;
        for (int k = 0; k < csm_pkg::NEEDLE_MAX; k++) begin
            if (csm_pkg::LEN_W'(k) < i_len) begin
                idx_full = i_len - 1'b1 - csm_pkg::LEN_W'(k);
                if (n_win[idx_full[csm_pkg::IDX_W-1:0]] !=
                    csm_pkg::fold_byte(i_needle[8*k +: 8])) begin
                    cmp_ok = 1'b0;
                end
            end
        end

        hit    = (n_filled >= i_len) && (r_blocked == '0) && cmp_ok;
        len_m1 = i_len - 1'b1;
        start  = (r_pos >= csm_pkg::POS_W'(len_m1)) ?
                 r_pos - csm_pkg::POS_W'(len_m1) : '0;

        n_total = r_total;
        if (hit && (r_total != '1)) begin
            n_total = r_total + 1'b1;
        end

        if (hit) begin
            n_blocked = len_m1[csm_pkg::IDX_W-1:0];
        end else if (r_blocked != '0) begin
            n_blocked = r_blocked - 1'b1;
        end else begin
            n_blocked = r_blocked;
        end

        n_pos = (r_pos != '1) ? r_pos + 1'b1 : r_pos;

        match_res.kind  = csm_pkg::KIND_MATCH;
        match_res.start = csm_pkg::START_W'(start);
        match_res.total = n_total;
        match_res.any   = 1'b1;
        match_res.last  = !i_last;

        sum_res.kind    = csm_pkg::KIND_SUMMARY;
        sum_res.start   = '0;
        sum_res.total   = n_total;
        sum_res.any     = (n_total != '0);
        sum_res.last    = 1'b1;

        o_push.push0 = i_accept && (hit || i_last);
        o_push.push1 = i_accept && hit && i_last;
        o_push.res0  = hit ? match_res : sum_res;
        o_push.res1  = sum_res;

        // end of text clears the run state
        if (i_last) begin
            n_filled  = '0;
            n_blocked = '0;
            n_pos     = '0;
            n_total   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled  <= '0;
            r_blocked <= '0;
            r_pos     <= '0;
            r_total   <= '0;
        end else if (i_accept) begin
            r_filled  <= n_filled;
            r_blocked <= n_blocked;
            r_pos     <= n_pos;
            r_total   <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int k = 0; k < csm_pkg::NEEDLE_MAX; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_pos == '0 && r_total == '0 && r_filled == '0))
        else $error("run state not cleared after end of text");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push1 |-> (o_push.push0 && o_push.res0.kind == csm_pkg::KIND_MATCH))
        else $error("summary pushed second without a match first");

    a_blocked_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blocked != '0) |-> (r_filled != '0))
        else $error("overlap guard active on an empty window");

endmodule

FILE: rtl/csm_res_fifo.sv
// small result queue between the matcher and the output stream
module csm_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csm_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_valid,
    output csm_pkg::t_result  o_res,
    input  logic              i_ready
);

    csm_pkg::t_result                r_mem [csm_pkg::RES_DEPTH];
    logic [csm_pkg::RES_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [csm_pkg::RES_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [csm_pkg::RES_PTR_W:0]     r_count, n_count;
    logic [csm_pkg::RES_PTR_W-1:0]   wr_ptr1;
    logic                            pop;

    always_comb begin
        o_valid  = (r_count != '0);
        o_res    = r_mem[r_rd_ptr];
        // two free slots cover the worst case of one byte
        o_room   = (r_count <= (csm_pkg::RES_PTR_W+1)'(csm_pkg::RES_DEPTH - 2));
        pop      = o_valid && i_ready;
        wr_ptr1  = r_wr_ptr + 1'b1;
        n_wr_ptr = r_wr_ptr + csm_pkg::RES_PTR_W'(i_push.push0)
                            + csm_pkg::RES_PTR_W'(i_push.push1);
        n_rd_ptr = r_rd_ptr + csm_pkg::RES_PTR_W'(pop);
        n_count  = r_count + (csm_pkg::RES_PTR_W+1)'(i_push.push0)
                           + (csm_pkg::RES_PTR_W+1)'(i_push.push1)
                           - (csm_pkg::RES_PTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (csm_pkg::RES_PTR_W+1)'(csm_pkg::RES_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push0 |-> o_room)
        else $error("result pushed without room");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.push0 && r_count == 1) |=> !o_valid)
        else $error("queue not empty after last result taken");

endmodule

FILE: rtl/case_insensitive_substring_matcher_core.sv
// top level of the case-insensitive non-overlapping substring matcher
// results: a transferred byte's results are written into the result queue as it transfers
//   and leave it in order; a second result (summary after a match) follows the first
// throughput: one byte per cycle while the master side keeps up; the 4-entry
//   result queue takes a byte whenever two slots are free
// reset: synchronous active-low i_rst_n clears the run state and the queue, sets
//   the needle bytes to zero and the needle length to one
module case_insensitive_substring_matcher_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side: text bytes
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // text_byte [7:0]
    input  logic                            i_s_tlast,   // end_of_text
    // master side: results
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [39:0]                     o_m_tdata,   // match_start [15:0],
                                                         // match_total [31:16],
                                                         // any_found [32], zero [39:33]
    output logic                            o_m_tuser,   // result_kind
    output logic                            o_m_tlast,   // last_of_run
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [csm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [csm_pkg::CFG_W-1:0]       i_cfg_wdata
);

    // configuration registers
    logic [csm_pkg::CFG_W-1:0]      r_needle_low;
    logic [csm_pkg::CFG_W-1:0]      r_needle_high;
    logic [4:0]                     r_needle_len;

    logic [csm_pkg::LEN_W-1:0]      used_len;
    logic [csm_pkg::NEEDLE_W-1:0]   needle;
    logic                           s_accept;
    logic                           room;
    csm_pkg::t_push                 push;
    csm_pkg::t_result               res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_needle_len  <= 5'd1;
        end else if (i_cfg_wr_en) begin
            case (csm_pkg::t_cfg_index'(i_cfg_index))
                csm_pkg::CFG_NEEDLE_LOW:  r_needle_low  <= i_cfg_wdata;
                csm_pkg::CFG_NEEDLE_HIGH: r_needle_high <= i_cfg_wdata;
                csm_pkg::CFG_NEEDLE_LEN:  r_needle_len  <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // length in use: zero acts as one, anything past the window as full width
    always_comb begin
        if (r_needle_len == '0) begin
            used_len = csm_pkg::LEN_W'(1);
        end else if (r_needle_len > 5'(csm_pkg::NEEDLE_MAX)) begin
            used_len = csm_pkg::LEN_W'(csm_pkg::NEEDLE_MAX);
        end else begin
            used_len = csm_pkg::LEN_W'(r_needle_len);
        end
        needle = csm_pkg::NEEDLE_W'({r_needle_high, r_needle_low});
    end

    // a byte transfers only when the queue can hold both of its possible results
    assign o_s_tready = room;
    assign s_accept   = i_s_tvalid && room;

    csm_matcher u_matcher (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_needle (needle),
        .i_len    (used_len),
        .o_push   (push)
    );

    csm_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .o_res   (res),
        .i_ready (i_m_tready)
    );

    // output packing, highest field first
    assign o_m_tdata = {7'd0, res.any, res.total, res.start};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;

endmodule

FILE: tb/sv/csm_match_checker.sv
// result predictor and scoreboard for the case-insensitive substring matcher
module csm_match_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [7:0]                    i_s_tdata,
    input  logic                          i_s_tlast,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [39:0]                   i_m_tdata,
    input  logic                          i_m_tuser,
    input  logic                          i_m_tlast,
    input  logic                          i_cfg_wr_en,
    input  logic [csm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [csm_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked
);

    localparam int POS_LIMIT = (1 << csm_pkg::POS_W) - 1;
    localparam logic [csm_pkg::CNT_W-1:0] COUNT_LIMIT = '1;

    typedef struct packed {
        csm_pkg::t_kind              kind;
        logic [csm_pkg::START_W-1:0] start;
        logic [csm_pkg::CNT_W-1:0]   total;
        logic                        any;
        logic                        last;
    } t_match_rec;

    t_match_rec       expected_q [$];

    // needle configuration as seen on the write port
    logic [csm_pkg::CFG_W-1:0] needle_lo;
    logic [csm_pkg::CFG_W-1:0] needle_hi;
    logic [4:0]                needle_len;

    // run state
    logic [7:0]                window [csm_pkg::NEEDLE_MAX];
    logic [csm_pkg::POS_W-1:0] pos;
    int                        next_start;
    logic [csm_pkg::CNT_W-1:0] total;
    int                        filled;
    int                        blocked;

    function automatic logic [7:0] upper_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] needle_byte(input int k);
        if (k < 8) begin
            return upper_case(needle_lo[k*8 +: 8]);
        end
        return upper_case(needle_hi[(k-8)*8 +: 8]);
    endfunction

    function automatic void clear_run();
        for (int k = 0; k < csm_pkg::NEEDLE_MAX; k++) begin
            window[k] = 8'h00;
        end
        pos        = '0;
        next_start = 0;
        total      = '0;
        filled     = 0;
        blocked    = 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_errors < 40) begin
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        o_errors++;
    endtask

    task automatic predict_text_byte(input logic [7:0] raw, input logic eot);
        logic [7:0] b;
        int         len;
        int         st;
        logic       hit;
        t_match_rec r;
        b   = upper_case(raw);
        len = (needle_len == 0) ? 1 :
              ((needle_len > csm_pkg::NEEDLE_MAX) ? csm_pkg::NEEDLE_MAX : int'(needle_len));
        for (int k = csm_pkg::NEEDLE_MAX - 1; k > 0; k--) begin
            window[k] = window[k-1];
        end
        window[0] = b;
        if (filled < csm_pkg::NEEDLE_MAX) begin
            filled++;
        end
        hit = (filled >= len) && (blocked == 0);
        for (int k = 0; k < len; k++) begin
            if (window[len-1-k] != needle_byte(k)) begin
                hit = 1'b0;
            end
        end
        if (blocked > 0) begin
            blocked--;
        end
        if (hit) begin
            st         = (int'(pos) >= len - 1) ? int'(pos) - (len - 1) : 0;
            next_start = (st + len > POS_LIMIT) ? POS_LIMIT : st + len;
            blocked    = len - 1;
            if (total != COUNT_LIMIT) begin
                total++;
            end
            r.kind  = csm_pkg::KIND_MATCH;
            r.start = st[csm_pkg::START_W-1:0];
            r.total = total;
            r.any   = 1'b1;
            r.last  = !eot;
            expected_q.push_back(r);
        end
        if (int'(pos) < POS_LIMIT) begin
            pos++;
        end
        if (eot) begin
            r.kind  = csm_pkg::KIND_SUMMARY;
            r.start = '0;
            r.total = total;
            r.any   = (total != 0);
            r.last  = 1'b1;
            expected_q.push_back(r);
            clear_run();
        end
    endtask

    task automatic compare_result();
        t_match_rec w;
        if (expected_q.size() == 0) begin
            report_mismatch("result with nothing expected", i_m_tdata[31:0], 32'd0);
            return;
        end
        w = expected_q.pop_front();
        o_checked++;
        if (i_m_tuser !== w.kind) begin
            report_mismatch("result_kind", 32'(i_m_tuser), 32'(w.kind));
        end
        if (i_m_tdata[15:0] !== w.start) begin
            report_mismatch("match_start", 32'(i_m_tdata[15:0]), 32'(w.start));
        end
        if (i_m_tdata[31:16] !== w.total) begin
            report_mismatch("match_total", 32'(i_m_tdata[31:16]), 32'(w.total));
        end
        if (i_m_tdata[32] !== w.any) begin
            report_mismatch("any_found", 32'(i_m_tdata[32]), 32'(w.any));
        end
        if (i_m_tdata[39:33] !== 7'd0) begin
            report_mismatch("tdata padding", 32'(i_m_tdata[39:33]), 32'd0);
        end
        if (i_m_tlast !== w.last) begin
            report_mismatch("last_of_run", 32'(i_m_tlast), 32'(w.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            needle_lo  = '0;
            needle_hi  = '0;
            needle_len = 5'd1;
            clear_run();
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                compare_result();
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    csm_pkg::CFG_NEEDLE_LOW:  needle_lo  = i_cfg_wdata;
                    csm_pkg::CFG_NEEDLE_HIGH: needle_hi  = i_cfg_wdata;
                    csm_pkg::CFG_NEEDLE_LEN:  needle_len = i_cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_text_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: tb/sv/case_insensitive_substring_matcher_core_tb.sv
// testbench top for the substring matcher: stimulus, pacing and verdict
module case_insensitive_substring_matcher_core_tb;

    localparam logic [csm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 4;     // a summary trails its match in the result queue
    localparam int RANDOM_BYTES   = 550;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = 8'h00;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [39:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              cfg_wr_en = 1'b0;
    logic [csm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [csm_pkg::CFG_W-1:0]     cfg_wdata = '0;

    int                errors;
    int                pending;
    int                checked;

    // pacing controls
    bit                tx_gaps   = 1'b1;
    bit                rx_stalls = 1'b1;
    bit                hold_req  = 1'b0;
    int                burst_left = 0;

    // needle copy used to build texts that actually match
    logic [7:0]        pattern [csm_pkg::NEEDLE_MAX];
    int                pat_len = 1;
    logic [7:0]        text_q [$];

    // run bookkeeping for the summary
    int                bytes_sent = 0;
    int                texts_sent = 0;
    int                settings   = 1;

    case_insensitive_substring_matcher_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    csm_match_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: ready/stall runs of random length, or a long counted hold-off
    int rx_run  = 0;
    bit rx_on   = 1'b0;
    int hold_left = 0;
    always @(negedge clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!rx_stalls) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_on  = !rx_on;
                rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            rx_run--;
            m_tready <= rx_on;
        end
    end

    // one register write per cycle; the caller lowers the enable after the batch
    task automatic cfg_write(input logic [csm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [csm_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic load_needle(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] len, input bit poke_unused);
        cfg_write(csm_pkg::CFG_NEEDLE_LOW, lo);
        cfg_write(csm_pkg::CFG_NEEDLE_HIGH, hi);
        cfg_write(csm_pkg::CFG_NEEDLE_LEN, {59'd0, len});
        if (poke_unused) begin
            // index with no register behind it, must change nothing
            cfg_write(CFG_UNUSED_INDEX, {$urandom, $urandom});
        end
        cfg_wr_en <= 1'b0;
        pat_len = (len == 0) ? 1 :
                  ((len > csm_pkg::NEEDLE_MAX) ? csm_pkg::NEEDLE_MAX : int'(len));
        for (int k = 0; k < csm_pkg::NEEDLE_MAX; k++) begin
            pattern[k] = (k < 8) ? lo[k*8 +: 8] : hi[(k-8)*8 +: 8];
        end
        settings++;
    endtask

    // offer one byte, honoring the burst/gap pattern, return once transferred
    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (tx_gaps && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[k]) begin
            send_byte(text_q[k], k == text_q.size() - 1);
        end
        texts_sent++;
    endtask

    // drain everything in flight so the needle may be rewritten
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'h41 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) begin
            c = c ^ 8'h20;
        end
        return c;
    endfunction

    // flip the case of letters at random, other bytes pass unchanged
    function automatic logic [7:0] vary_case(input logic [7:0] c);
        logic is_letter;
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        if (is_letter && $urandom_range(0, 1)) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] noise_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            return 8'($urandom_range(0, 255));
        end else if (sel < 7) begin
            return rand_letter();
        end
        return vary_case(pattern[$urandom_range(0, pat_len - 1)]);
    endfunction

    // mostly whole needle copies, some cut short, some plain noise
    task automatic build_text(input int segments, input bit dense);
        int sel;
        int cut;
        text_q.delete();
        repeat (segments) begin
            sel = dense ? 0 : $urandom_range(0, 9);
            if (sel < 6) begin
                for (int k = 0; k < pat_len; k++) begin
                    text_q.push_back(vary_case(pattern[k]));
                end
            end else if (sel < 8) begin
                cut = $urandom_range(0, pat_len - 1);
                for (int k = 0; k < cut; k++) begin
                    text_q.push_back(vary_case(pattern[k]));
                end
                text_q.push_back(noise_byte());
            end else begin
                repeat ($urandom_range(1, 4)) text_q.push_back(noise_byte());
            end
        end
        if (text_q.size() == 0) begin
            text_q.push_back(noise_byte());
        end
    endtask

    // random needle over a small alphabet so texts hit often;
    // force_len < 0 picks a length, mostly short, sometimes out of range
    task automatic random_needle(input int force_len);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  c;
        int          len;
        int          sel;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if (force_len >= 0) begin
            len = force_len;
        end else begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                len = $urandom_range(1, 4);
            end else if (sel < 9) begin
                len = $urandom_range(5, 16);
            end else begin
                len = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
            end
        end
        for (int k = 0; k < csm_pkg::NEEDLE_MAX; k++) begin
            sel = $urandom_range(0, 19);
            if (sel < 12) begin
                c = 8'h41 + 8'($urandom_range(0, 3));
                if ($urandom_range(0, 1)) begin
                    c = c ^ 8'h20;
                end
            end else if (sel < 15) begin
                // neighbors of the letter ranges that must not fold
                case ($urandom_range(0, 3))
                    0:       c = 8'h40;
                    1:       c = 8'h5B;
                    2:       c = 8'h60;
                    default: c = 8'h7B;
                endcase
            end else begin
                c = 8'($urandom_range(0, 255));
            end
            if (k < 8) begin
                lo[k*8 +: 8] = c;
            end else begin
                hi[(k-8)*8 +: 8] = c;
            end
        end
        load_needle(lo, hi, 5'(len), $urandom_range(0, 7) == 0);
    endtask

    initial begin
        int base;
        int rnd_texts;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset needle is a single zero byte; byte value extremes
        text_q = '{8'h00, 8'hFF, 8'h00};
        send_text();
        settle();

        // needle "aA": no overlapping matches, then a match on the final byte
        load_needle(64'h4161, 64'h0, 5'd2, 1'b1);
        text_q = '{8'h61, 8'h41, 8'h61, 8'h61, 8'h41};
        send_text();
        text_q = '{8'h78, 8'h61, 8'h41};
        send_text();
        settle();

        // text shorter than the needle
        load_needle(64'h44434241, 64'h0, 5'd4, 1'b0);
        text_q = '{8'h61, 8'h62};
        send_text();
        settle();

        // only a-z fold: the neighbors of the letter ranges stay as they are
        load_needle(64'h7B7A60, 64'h0, 5'd3, 1'b0);
        text_q = '{8'h60, 8'h5A, 8'h7B};
        send_text();
        text_q = '{8'h40, 8'h5A, 8'h5B};
        send_text();
        settle();

        // length zero behaves as one
        load_needle(64'hFF, 64'h0, 5'd0, 1'b0);
        text_q = '{8'hFF};
        send_text();
        settle();

        // random texts, needle changed every few texts
        base      = bytes_sent;
        rnd_texts = 0;
        while (bytes_sent - base < RANDOM_BYTES) begin
            if (rnd_texts % 3 == 0) begin
                settle();
                if (rnd_texts == 3) begin
                    random_needle(16);
                end else if (rnd_texts == 6) begin
                    random_needle(31);
                end else begin
                    random_needle(-1);
                end
            end
            tx_gaps   = ($urandom_range(0, 4) != 0);
            rx_stalls = ($urandom_range(0, 4) != 0);
            if (rnd_texts == 4 || rnd_texts == 20) begin
                // receiver holds off while a text full of matches keeps coming
                hold_req = 1'b1;
                build_text(14, 1'b1);
            end else begin
                build_text($urandom_range(1, 6), 1'b0);
            end
            send_text();
            rnd_texts++;
        end

        settle();
        repeat (16) @(negedge clk);

        $display("run covered %0d text bytes in %0d texts under %0d needle settings",
                 bytes_sent, texts_sent, settings);
        $display("%0d results checked, with receiver hold-offs that filled the queue",
                 checked);
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/csm_pkg.sv
rtl/csm_matcher.sv
rtl/csm_res_fifo.sv
rtl/case_insensitive_substring_matcher_core.sv
tb/sv/csm_match_checker.sv
tb/sv/case_insensitive_substring_matcher_core_tb.sv
